>>> rtl/bfr_pkg.sv
`default_nettype none
package bfr_pkg;

	localparam int unsigned NUM_BINS    = 64;
	localparam int unsigned BIN_US      = 1000000;
	localparam int unsigned NUM_CLASSES = 9;

	localparam int unsigned BIN_W = $clog2(NUM_BINS);
	localparam int unsigned CLS_W = $clog2(NUM_CLASSES);

	localparam logic [31:0] BIN_US_W  = 32'(BIN_US);
	localparam logic [63:0] RING_SPAN = 64'(BIN_US) * 64'(NUM_BINS);

	// opcodes
	localparam logic [2:0] OP_RX    = 3'd0;
	localparam logic [2:0] OP_TX    = 3'd1;
	localparam logic [2:0] OP_LOCK  = 3'd2;
	localparam logic [2:0] OP_RETRY = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// frame classes
	localparam logic [CLS_W-1:0] CLS_OTHER = CLS_W'(0);
	localparam logic [CLS_W-1:0] CLS_ARP   = CLS_W'(1);
	localparam logic [CLS_W-1:0] CLS_IPV6  = CLS_W'(2);
	localparam logic [CLS_W-1:0] CLS_TCP   = CLS_W'(3);
	localparam logic [CLS_W-1:0] CLS_API   = CLS_W'(4);
	localparam logic [CLS_W-1:0] CLS_HTTP  = CLS_W'(5);
	localparam logic [CLS_W-1:0] CLS_UDP   = CLS_W'(6);
	localparam logic [CLS_W-1:0] CLS_NTP   = CLS_W'(7);
	localparam logic [CLS_W-1:0] CLS_MDNS  = CLS_W'(8);

	localparam logic [15:0] ET_ARP  = 16'h0806;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;
	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [15:0] PORT_API  = 16'd6053;
	localparam logic [15:0] PORT_HTTP = 16'd80;
	localparam logic [15:0] PORT_NTP  = 16'd123;
	localparam logic [15:0] PORT_MDNS = 16'd5353;
	localparam logic [15:0] SAT16 = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] now_us;
		logic [15:0] ether_type;
		logic [3:0]  ip_header_words;
		logic [7:0]  ip_protocol;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [13:0] frame_length;
		logic [31:0] wait_us;
		logic [7:0]  bin_index;
		logic [3:0]  class_index;
	} item_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] bin_start_us;
		logic [15:0] rx_count;
		logic [15:0] tx_count;
		logic [31:0] rx_byte_total;
		logic [31:0] tx_byte_total;
		logic [31:0] lock_wait_peak_us;
		logic [15:0] retry_count;
	} result_t;

	typedef struct packed {
		logic [31:0]                        start;
		logic [NUM_CLASSES-1:0][15:0]       rx_cnt;
		logic [NUM_CLASSES-1:0][15:0]       tx_cnt;
		logic [31:0]                        rx_octets;
		logic [31:0]                        tx_octets;
		logic [31:0]                        peak;
		logic [15:0]                        retries;
	} row_t;

endpackage
`default_nettype wire

>>> rtl/bfr_item_if.sv
`default_nettype none
interface bfr_item_if;
	logic            valid;
	logic            ready;
	bfr_pkg::item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bfr_result_if.sv
`default_nettype none
interface bfr_result_if;
	logic             valid;
	logic             ready;
	bfr_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bfr_classify.sv
`default_nettype none
module bfr_classify (
	input  wire bfr_pkg::item_t               item,
	output logic [bfr_pkg::CLS_W-1:0]         cls
);
	logic [5:0]  ihl;
	logic [14:0] need_len;
	logic        tcp_api, tcp_http, udp_ntp, udp_mdns;

	assign ihl      = {item.ip_header_words, 2'b00};
	assign need_len = 15'd18 + 15'(ihl);
	assign tcp_api  = item.src_port == bfr_pkg::PORT_API  || item.dst_port == bfr_pkg::PORT_API;
	assign tcp_http = item.src_port == bfr_pkg::PORT_HTTP || item.dst_port == bfr_pkg::PORT_HTTP;
	assign udp_ntp  = item.src_port == bfr_pkg::PORT_NTP  || item.dst_port == bfr_pkg::PORT_NTP;
	assign udp_mdns = item.src_port == bfr_pkg::PORT_MDNS || item.dst_port == bfr_pkg::PORT_MDNS;

	always_comb begin
		cls = bfr_pkg::CLS_OTHER;
		if (item.frame_length < 14'd14) begin
			cls = bfr_pkg::CLS_OTHER;
		end else if (item.ether_type == bfr_pkg::ET_ARP) begin
			cls = bfr_pkg::CLS_ARP;
		end else if (item.ether_type == bfr_pkg::ET_IPV6) begin
			cls = bfr_pkg::CLS_IPV6;
		end else if (item.ether_type != bfr_pkg::ET_IPV4 || item.frame_length < 14'd34) begin
			cls = bfr_pkg::CLS_OTHER;
		end else if (ihl < 6'd20 || 15'(item.frame_length) < need_len) begin
			cls = bfr_pkg::CLS_OTHER;
		end else if (item.ip_protocol == bfr_pkg::PROTO_TCP) begin
			cls = tcp_api ? bfr_pkg::CLS_API : (tcp_http ? bfr_pkg::CLS_HTTP : bfr_pkg::CLS_TCP);
		end else if (item.ip_protocol == bfr_pkg::PROTO_UDP) begin
			cls = udp_ntp ? bfr_pkg::CLS_NTP : (udp_mdns ? bfr_pkg::CLS_MDNS : bfr_pkg::CLS_UDP);
		end
	end
endmodule
`default_nettype wire

>>> rtl/binned_frame_traffic_recorder.sv
`default_nettype none
// Binned frame traffic recorder. Events come in one at a time on the item channel and
// the block is busy until it has finished with each one. A recording event passes
// through accept, ring check, row read and row write-back; the ring check is repeated
// for each bin the ring steps forward, while a restart after a full ring of silence
// clears all bins at once with no repeat. A read passes through accept, row read and
// result load, and its result is held in an output register until taken; a read that
// finds the previous result still waiting stalls in result load until that result is
// taken. All bins share one 32-bit elapsed-time subtractor and one row memory with a
// single read and a single write port; a per-bin valid bit makes unwritten bins read
// as zero, so no clearing pass is needed after reset. Recording events are dropped
// while the enable bit written through cfg_we/cfg_wdata is low; reads always work.
module binned_frame_traffic_recorder (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire               cfg_wdata,
	bfr_item_if.sink          item,
	bfr_result_if.source      result
);
	localparam int unsigned BIN_W = bfr_pkg::BIN_W;
	localparam int unsigned SUM_W = ((BIN_W > 8) ? BIN_W : 8) + 2;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADV   = 3'd1;
	localparam logic [2:0] S_URD   = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_RDOUT = 3'd5;

	logic [2:0]                state_q;
	logic                      enable_q;
	bfr_pkg::item_t            item_q;
	logic [BIN_W-1:0]          cur_bin_q;
	logic [31:0]               cur_start_q;
	logic [bfr_pkg::NUM_BINS-1:0] row_vld_q;
	logic                      idx_ok_q;
	logic                      adv_first_q;

	// row memory
	bfr_pkg::row_t             mem [bfr_pkg::NUM_BINS];
	bfr_pkg::row_t             rd_row_q;
	logic                      rd_vld_q;
	logic                      mem_we, mem_re;
	logic [BIN_W-1:0]          mem_waddr, mem_raddr;
	bfr_pkg::row_t             mem_wdata;

	logic                      res_vld_q;
	bfr_pkg::result_t          res_q;

	logic [bfr_pkg::CLS_W-1:0] cls;
	logic [31:0]               elapsed;
	logic                      restart, step;
	logic [BIN_W-1:0]          next_bin;
	logic [31:0]               next_start;
	logic [SUM_W-1:0]          age_sum;
	logic [BIN_W-1:0]          rd_bin;
	logic                      idx_ok;
	bfr_pkg::row_t             eff_row, upd_row, step_row;
	bfr_pkg::result_t          rd_res;

	bfr_classify u_classify (
		.item (item_q),
		.cls  (cls)
	);

	// shared elapsed-time unit; the full-ring check is made only on the first ring cycle
	assign elapsed    = item_q.now_us - cur_start_q;
	assign restart    = adv_first_q &&
		(cur_start_q == 32'd0 || {32'd0, elapsed} >= bfr_pkg::RING_SPAN);
	assign step       = elapsed >= bfr_pkg::BIN_US_W;
	assign next_bin   = (32'(cur_bin_q) == bfr_pkg::NUM_BINS - 1) ? '0 : cur_bin_q + 1'b1;
	assign next_start = cur_start_q + bfr_pkg::BIN_US_W;

	// age index to ring position, one conditional subtract
	always_comb begin
		age_sum = SUM_W'(cur_bin_q) + SUM_W'(1) + SUM_W'(item_q.bin_index);
		if (age_sum >= SUM_W'(bfr_pkg::NUM_BINS))
			age_sum = age_sum - SUM_W'(bfr_pkg::NUM_BINS);
	end
	assign rd_bin = age_sum[BIN_W-1:0];
	assign idx_ok = SUM_W'(item_q.bin_index) < SUM_W'(bfr_pkg::NUM_BINS);

	// a bin never written since the last full clear reads as zero
	assign eff_row = rd_vld_q ? rd_row_q : '0;

	always_comb begin
		step_row       = '0;
		step_row.start = restart ? item_q.now_us : next_start;
	end

	// read-modify-write of the current bin
	always_comb begin
		upd_row = eff_row;
		case (item_q.opcode)
			bfr_pkg::OP_RX: begin
				if (eff_row.rx_cnt[cls] != bfr_pkg::SAT16)
					upd_row.rx_cnt[cls] = eff_row.rx_cnt[cls] + 16'd1;
				upd_row.rx_octets = eff_row.rx_octets + 32'(item_q.frame_length);
			end
			bfr_pkg::OP_TX: begin
				if (eff_row.tx_cnt[cls] != bfr_pkg::SAT16)
					upd_row.tx_cnt[cls] = eff_row.tx_cnt[cls] + 16'd1;
				upd_row.tx_octets = eff_row.tx_octets + 32'(item_q.frame_length);
			end
			bfr_pkg::OP_LOCK: begin
				if (item_q.wait_us > eff_row.peak)
					upd_row.peak = item_q.wait_us;
			end
			bfr_pkg::OP_RETRY: begin
				if (eff_row.retries != bfr_pkg::SAT16)
					upd_row.retries = eff_row.retries + 16'd1;
			end
			default: upd_row = eff_row;
		endcase
	end

	// read result
	always_comb begin
		rd_res = '0;
		if (idx_ok_q) begin
			rd_res.valid_res         = eff_row.start != 32'd0;
			rd_res.bin_start_us      = eff_row.start;
			rd_res.rx_byte_total     = eff_row.rx_octets;
			rd_res.tx_byte_total     = eff_row.tx_octets;
			rd_res.lock_wait_peak_us = eff_row.peak;
			rd_res.retry_count       = eff_row.retries;
			if (32'(item_q.class_index) < bfr_pkg::NUM_CLASSES) begin
				rd_res.rx_count = eff_row.rx_cnt[item_q.class_index[bfr_pkg::CLS_W-1:0]];
				rd_res.tx_count = eff_row.tx_cnt[item_q.class_index[bfr_pkg::CLS_W-1:0]];
			end
		end
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_bin_q;
		mem_wdata = upd_row;
		mem_re    = 1'b0;
		mem_raddr = cur_bin_q;
		case (state_q)
			S_ADV: begin
				if (restart) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = step_row;
				end else if (step) begin
					mem_we    = 1'b1;
					mem_waddr = next_bin;
					mem_wdata = step_row;
				end
			end
			S_URD: mem_re = 1'b1;
			S_UPD: mem_we = 1'b1;
			S_RD: begin
				mem_re    = 1'b1;
				mem_raddr = rd_bin;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_row_q <= mem[mem_raddr];
	end

	assign item.ready   = state_q == S_IDLE;
	assign result.valid = res_vld_q;
	assign result.data  = res_q;

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			item_q <= item.data;
		if (state_q == S_RD)
			idx_ok_q <= idx_ok;
		if (state_q == S_RDOUT && (!res_vld_q || result.ready))
			res_q <= rd_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enable_q    <= 1'b0;
			cur_bin_q   <= '0;
			cur_start_q <= 32'd0;
			row_vld_q   <= '0;
			rd_vld_q    <= 1'b0;
			res_vld_q   <= 1'b0;
			adv_first_q <= 1'b0;
		end else begin
			if (cfg_we)
				enable_q <= cfg_wdata;
			// output slot: loaded at the end of a read, freed when taken
			if (state_q == S_RDOUT && (!res_vld_q || result.ready))
				res_vld_q <= 1'b1;
			else if (result.ready)
				res_vld_q <= 1'b0;
			if (mem_re)
				rd_vld_q <= row_vld_q[mem_raddr];
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						if (item.data.opcode == bfr_pkg::OP_READ) begin
							state_q <= S_RD;
						end else if (item.data.opcode < bfr_pkg::OP_READ && enable_q) begin
							state_q     <= S_ADV;
							adv_first_q <= 1'b1;
						end
					end
				end
				S_ADV: begin
					adv_first_q <= 1'b0;
					if (restart) begin
						// full clear, ring restarts at bin zero
						row_vld_q   <= bfr_pkg::NUM_BINS'(1);
						cur_bin_q   <= '0;
						cur_start_q <= item_q.now_us;
						state_q     <= S_URD;
					end else if (step) begin
						row_vld_q[next_bin] <= 1'b1;
						cur_bin_q           <= next_bin;
						cur_start_q         <= next_start;
					end else begin
						state_q <= S_URD;
					end
				end
				S_URD: state_q <= S_UPD;
				S_UPD: state_q <= S_IDLE;
				S_RD:  state_q <= S_RDOUT;
				S_RDOUT: begin
					if (!res_vld_q || result.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result only appears after a read sequence
	a_res_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q) == S_RDOUT)
		else $error("result without read");

	// current bin always on the ring
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_bin_q) < bfr_pkg::NUM_BINS)
		else $error("current bin out of range");

	// a restart leaves only bin zero valid
	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADV && restart) |=> (row_vld_q == bfr_pkg::NUM_BINS'(1) && cur_bin_q == '0))
		else $error("restart did not clear ring");

	// the current bin is valid whenever its row is updated
	a_cur_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> row_vld_q[cur_bin_q])
		else $error("update of unstarted bin");
endmodule
`default_nettype wire
